### hdl/rad_pkg.sv
// ----------------------------------------------------------------------------
// rad_pkg
// Shared types and constants of the ratiometric ADC averager.
// ----------------------------------------------------------------------------
`default_nettype none

package rad_pkg;

    localparam int AVG_W   = 8;    // avg_count register width
    localparam int MV_W    = 12;   // ref_millivolts register width
    localparam int OUT_W   = 16;   // result field width
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [AVG_W-1:0] AVG_COUNT_RESET = AVG_W'(10);
    localparam logic [MV_W-1:0]  REF_MV_RESET    = MV_W'(1200);
    localparam logic [OUT_W-1:0] OUT_SAT         = {OUT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_AVG_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MV    = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CH_A,
        CH_B,
        CH_REF
    } t_chan;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG_LOAD,
        S_AVG_RUN,
        S_CHECK,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic  accum;      // add scan into running sums
        logic  restart;    // drop scan, phase back to zero
        logic  avg_load;   // load divider: sum / avg_count
        logic  div_load;   // load divider: avg * mv / avg_ref
        logic  div_step;   // one restoring-division step
        logic  avg_store;  // capture average from last step
        logic  res_store;  // capture saturated result from last step
        logic  out_zero;   // present zero-reference result
        logic  out_set;    // present computed result
        t_chan chan;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit;       // next scan triggers a result
        logic out_busy;   // output register still holds a beat
        logic div_last;   // divider is on its final step
        logic ref_zero;   // reference average is zero
    } t_dp_stat;

    function automatic t_chan next_chan(input t_chan c);
        t_chan r;
        unique case (c)
            CH_A:    r = CH_B;
            CH_B:    r = CH_REF;
            default: r = CH_A;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/rad_ctrl.sv
// ----------------------------------------------------------------------------
// rad_ctrl
// Sequencer: accepts scans, then walks the shared divider through the three
// averages and the three ratiometric results (skipped for a zero reference).
// ----------------------------------------------------------------------------
`default_nettype none

module rad_ctrl
    import rad_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;
    t_chan  r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= CH_A;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.chan = r_idx;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                // a result-producing scan waits for a free output register
                o_in_stall = i_stat.emit && i_stat.out_busy;
                if (i_in_valid && !o_in_stall) begin
                    if (i_stat.emit) begin
                        o_cmd.restart = 1'b1;
                        n_idx         = CH_A;
                        n_state       = S_AVG_LOAD;
                    end else begin
                        o_cmd.accum = 1'b1;
                    end
                end
            end
            S_AVG_LOAD: begin
                o_cmd.avg_load = 1'b1;
                n_state        = S_AVG_RUN;
            end
            S_AVG_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    o_cmd.avg_store = 1'b1;
                    if (r_idx == CH_REF) begin
                        n_state = S_CHECK;
                    end else begin
                        n_idx   = next_chan(r_idx);
                        n_state = S_AVG_LOAD;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.ref_zero) begin
                    o_cmd.out_zero = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_idx   = CH_A;
                    n_state = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    o_cmd.res_store = 1'b1;
                    if (r_idx == CH_REF) begin
                        n_state = S_FINISH;
                    end else begin
                        n_idx   = next_chan(r_idx);
                        n_state = S_DIV_LOAD;
                    end
                end
            end
            S_FINISH: begin
                o_cmd.out_set = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/rad_dp.sv
// ----------------------------------------------------------------------------
// rad_dp
// Datapath: configuration registers, phase counter, running sums, one
// multiplier, one shared restoring divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rad_dp
    import rad_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_a,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_b,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_ref,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_stat                    o_stat,
    input  wire logic                   i_out_stall,
    output logic                        o_out_valid,
    output logic [OUT_W-1:0]            o_volt_a,
    output logic [OUT_W-1:0]            o_volt_b,
    output logic [OUT_W-1:0]            o_supply_mv,
    output logic                        o_ref_zero
);

    localparam int SUM_W  = SAMPLE_BITS + AVG_W;
    localparam int PROD_W = SUM_W + MV_W;
    localparam int CNT_W  = $clog2(PROD_W);

    logic [AVG_W-1:0]  r_avg_count;
    logic [MV_W-1:0]   r_ref_mv;
    logic [AVG_W-1:0]  r_phase;
    logic [SUM_W-1:0]  r_sum_a, r_sum_b, r_sum_r;
    logic [SUM_W-1:0]  r_avg_a, r_avg_b, r_avg_r;

    logic [SUM_W-1:0]  r_divisor;
    logic [SUM_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;

    logic [OUT_W-1:0]  r_volt_a, r_volt_b, r_supply;
    logic              r_ref_zero;
    logic              r_out_valid;

    logic [AVG_W-1:0]  avg_eff;
    logic [SUM_W:0]    rem_sh;
    logic              quo_bit;
    logic [SUM_W-1:0]  n_rem;
    logic [PROD_W-1:0] n_quo;
    logic [OUT_W-1:0]  res_sat;
    logic [SUM_W-1:0]  sum_sel;
    logic [PROD_W-1:0] prod;

    // zero count behaves as one
    assign avg_eff = (r_avg_count == '0) ? AVG_W'(1) : r_avg_count;

    // restoring division, one quotient bit per step
    assign rem_sh  = {r_rem, r_quo[PROD_W-1]};
    assign quo_bit = rem_sh >= {1'b0, r_divisor};
    assign n_rem   = quo_bit ? SUM_W'(rem_sh - {1'b0, r_divisor}) : rem_sh[SUM_W-1:0];
    assign n_quo   = {r_quo[PROD_W-2:0], quo_bit};
    assign res_sat = (|n_quo[PROD_W-1:OUT_W]) ? OUT_SAT : n_quo[OUT_W-1:0];

    always_comb begin
        case (i_cmd.chan)
            CH_A:    sum_sel = r_sum_a;
            CH_B:    sum_sel = r_sum_b;
            default: sum_sel = r_sum_r;
        endcase
    end

    always_comb begin
        case (i_cmd.chan)
            CH_A:    prod = PROD_W'(r_avg_a) * PROD_W'(r_ref_mv);
            CH_B:    prod = PROD_W'(r_avg_b) * PROD_W'(r_ref_mv);
            default: prod = PROD_W'(r_ref_mv) << SAMPLE_BITS;
        endcase
    end

    // configuration, phase and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_count <= AVG_COUNT_RESET;
            r_ref_mv    <= REF_MV_RESET;
            r_phase     <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_sum_r     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_AVG_COUNT: r_avg_count <= i_cfg_data[AVG_W-1:0];
                    CFG_REF_MV:    r_ref_mv    <= i_cfg_data[MV_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accum) begin
                // first scan of a block starts from empty sums
                if (r_phase == '0) begin
                    r_sum_a <= SUM_W'(i_sample_a);
                    r_sum_b <= SUM_W'(i_sample_b);
                    r_sum_r <= SUM_W'(i_sample_ref);
                end else begin
                    r_sum_a <= r_sum_a + SUM_W'(i_sample_a);
                    r_sum_b <= r_sum_b + SUM_W'(i_sample_b);
                    r_sum_r <= r_sum_r + SUM_W'(i_sample_ref);
                end
                r_phase <= r_phase + AVG_W'(1);
            end
            if (i_cmd.restart) begin
                r_phase <= '0;
            end
            if (i_cmd.out_zero || i_cmd.out_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider, averages and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.avg_load) begin
            r_divisor <= SUM_W'(avg_eff);
            r_quo     <= PROD_W'(sum_sel);
            r_rem     <= '0;
            r_cnt     <= CNT_W'(PROD_W - 1);
        end else if (i_cmd.div_load) begin
            r_divisor <= r_avg_r;
            r_quo     <= prod;
            r_rem     <= '0;
            r_cnt     <= CNT_W'(PROD_W - 1);
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.avg_store) begin
            case (i_cmd.chan)
                CH_A:    r_avg_a <= n_quo[SUM_W-1:0];
                CH_B:    r_avg_b <= n_quo[SUM_W-1:0];
                default: r_avg_r <= n_quo[SUM_W-1:0];
            endcase
        end
        if (i_cmd.res_store) begin
            case (i_cmd.chan)
                CH_A:    r_volt_a <= res_sat;
                CH_B:    r_volt_b <= res_sat;
                default: r_supply <= res_sat;
            endcase
        end
        if (i_cmd.out_zero) begin
            r_volt_a   <= OUT_SAT;
            r_volt_b   <= OUT_SAT;
            r_supply   <= OUT_SAT;
            r_ref_zero <= 1'b1;
        end else if (i_cmd.out_set) begin
            r_ref_zero <= 1'b0;
        end
    end

    assign o_stat.emit     = r_phase >= avg_eff;
    assign o_stat.out_busy = r_out_valid;
    assign o_stat.div_last = r_cnt == '0;
    assign o_stat.ref_zero = r_avg_r == '0;

    assign o_out_valid = r_out_valid;
    assign o_volt_a    = r_volt_a;
    assign o_volt_b    = r_volt_b;
    assign o_supply_mv = r_supply;
    assign o_ref_zero  = r_ref_zero;

endmodule

`default_nettype wire

### hdl/ratiometric_adc_averager_unit.sv
// Accumulating scan: added to the running sums on acceptance, no result.
// Result scan: the three averages, then, unless the reference average is zero,
// the three ratiometric results are computed by one restoring divider shared
// by six divisions, one bit per cycle.
// Synchronous active-low reset: avg_count 10, ref_millivolts 1200, phase 0.
// ----------------------------------------------------------------------------
// ratiometric_adc_averager_unit
// Block averager of two channels plus internal reference, with ratiometric
// conversion to millivolts and a supply estimate.
// ----------------------------------------------------------------------------
`default_nettype none

module ratiometric_adc_averager_unit
    import rad_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_a,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_b,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_ref,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [OUT_W-1:0]            o_volt_a,
    output logic [OUT_W-1:0]            o_volt_b,
    output logic [OUT_W-1:0]            o_supply_mv,
    output logic                        o_ref_zero
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    rad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rad_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_a   (i_sample_a),
        .i_sample_b   (i_sample_b),
        .i_sample_ref (i_sample_ref),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_volt_a     (o_volt_a),
        .o_volt_b     (o_volt_b),
        .o_supply_mv  (o_supply_mv),
        .o_ref_zero   (o_ref_zero)
    );

endmodule

`default_nettype wire

### hdl/rad_chk.sv
// ----------------------------------------------------------------------------
// rad_chk
// Port-level checks of the averager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rad_chk
    import rad_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_stall,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_stall,
    input wire logic [OUT_W-1:0]       o_volt_a,
    input wire logic [OUT_W-1:0]       o_volt_b,
    input wire logic [OUT_W-1:0]       o_supply_mv,
    input wire logic                   o_ref_zero
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_volt_a)
            && $stable(o_volt_b) && $stable(o_supply_mv) && $stable(o_ref_zero))
        else $error("result beat changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ref_zero |-> o_volt_a == OUT_SAT && o_volt_b == OUT_SAT
            && o_supply_mv == OUT_SAT)
        else $error("zero reference result not saturated");

    // a result never appears right after a scan is taken or while scans flow
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall) && !$past(i_in_valid && !o_in_stall))
        else $error("result appeared without computation");

endmodule

bind ratiometric_adc_averager_unit rad_chk u_rad_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_volt_a    (o_volt_a),
    .o_volt_b    (o_volt_b),
    .o_supply_mv (o_supply_mv),
    .o_ref_zero  (o_ref_zero)
);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ratiometric ADC averager: scans are fed through
// a stall handshake, each accepted scan is folded into a local copy of the
// phase counter and channel sums, and every result beat is compared field by
// field with the oldest predicted reading. Register settings change between
// drained phases, from directed corner cases to random windows and references.
// ----------------------------------------------------------------------------

module tb;
    import rad_pkg::*;

    localparam int SAMPLE_BITS   = 12;
    localparam int SUM_W         = SAMPLE_BITS + 8;
    localparam int SCAN_TARGET   = 650;
    localparam int SETTLE_CYCLES = 220;
    localparam longint TIMEOUT_NS = 64'd40_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] samp_a;
        logic [SAMPLE_BITS-1:0] samp_b;
        logic [SAMPLE_BITS-1:0] samp_ref;
    } t_scan;

    typedef struct packed {
        logic [OUT_W-1:0] volt_a;
        logic [OUT_W-1:0] volt_b;
        logic [OUT_W-1:0] supply_mv;
        logic             ref_zero;
    } t_reading;

    typedef enum int {
        FLAV_ANY,
        FLAV_LOW_REF,
        FLAV_RAILS,
        FLAV_HIGH
    } t_flavor;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index  = CFG_AVG_COUNT;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic [SAMPLE_BITS-1:0] i_sample_a   = '0;
    logic [SAMPLE_BITS-1:0] i_sample_b   = '0;
    logic [SAMPLE_BITS-1:0] i_sample_ref = '0;
    logic                   i_out_stall  = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [OUT_W-1:0]       o_volt_a;
    logic [OUT_W-1:0]       o_volt_b;
    logic [OUT_W-1:0]       o_supply_mv;
    logic                   o_ref_zero;

    ratiometric_adc_averager_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_a   (i_sample_a),
        .i_sample_b   (i_sample_b),
        .i_sample_ref (i_sample_ref),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_volt_a     (o_volt_a),
        .o_volt_b     (o_volt_b),
        .o_supply_mv  (o_supply_mv),
        .o_ref_zero   (o_ref_zero)
    );

    always #10 i_clk = ~i_clk;

    // local copy of the block's registers and state
    logic [AVG_W-1:0] avg_count_q;
    logic [MV_W-1:0]  ref_mv_q;
    logic [7:0]       scan_phase;
    logic [SUM_W-1:0] chan_sum [3];

    t_scan    scan_queue[$];
    t_reading expected_readings[$];
    t_scan    pending_scan;

    logic in_fire  = 1'b0;
    logic cfg_fire = 1'b0;
    logic idling   = 1'b1;
    int   in_gap   = 0;
    int   out_gap  = 0;

    int mismatches       = 0;
    int readings_checked = 0;
    int zero_ref_seen    = 0;
    int clipped_seen     = 0;
    int scans_sent       = 0;
    int settings_visited = 0;

    function automatic logic [OUT_W-1:0] clip_mv(logic [63:0] v);
        return (v > 64'(OUT_SAT)) ? OUT_SAT : v[OUT_W-1:0];
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_AVG_COUNT: avg_count_q = val[AVG_W-1:0];
            CFG_REF_MV:    ref_mv_q    = val[MV_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void fold_scan(t_scan s);
        logic [AVG_W-1:0] n;
        logic [63:0]      avg_a;
        logic [63:0]      avg_b;
        logic [63:0]      avg_r;
        t_reading         rd;
        n = (avg_count_q == '0) ? AVG_W'(1) : avg_count_q;
        if (scan_phase == '0) begin
            chan_sum[CH_A]   = '0;
            chan_sum[CH_B]   = '0;
            chan_sum[CH_REF] = '0;
        end
        if (scan_phase < n) begin
            chan_sum[CH_A]   = chan_sum[CH_A] + SUM_W'(s.samp_a);
            chan_sum[CH_B]   = chan_sum[CH_B] + SUM_W'(s.samp_b);
            chan_sum[CH_REF] = chan_sum[CH_REF] + SUM_W'(s.samp_ref);
            scan_phase = scan_phase + 8'd1;
        end else begin
            // drop the scan, close the window
            scan_phase = '0;
            avg_a = 64'(chan_sum[CH_A]) / 64'(n);
            avg_b = 64'(chan_sum[CH_B]) / 64'(n);
            avg_r = 64'(chan_sum[CH_REF]) / 64'(n);
            if (avg_r == 0) begin
                rd = '{OUT_SAT, OUT_SAT, OUT_SAT, 1'b1};
            end else begin
                rd.volt_a    = clip_mv(avg_a * 64'(ref_mv_q) / avg_r);
                rd.volt_b    = clip_mv(avg_b * 64'(ref_mv_q) / avg_r);
                rd.supply_mv = clip_mv((64'd1 << SAMPLE_BITS) * 64'(ref_mv_q) / avg_r);
                rd.ref_zero  = 1'b0;
            end
            expected_readings.push_back(rd);
        end
    endfunction

    function automatic void check_field(string name, logic [OUT_W-1:0] want,
                                        logic [OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic t_scan random_scan(t_flavor flav);
        t_scan s;
        s.samp_a   = SAMPLE_BITS'($urandom);
        s.samp_b   = SAMPLE_BITS'($urandom);
        s.samp_ref = SAMPLE_BITS'($urandom);
        case (flav)
            FLAV_LOW_REF: s.samp_ref = SAMPLE_BITS'($urandom_range(0, 2));
            FLAV_RAILS: begin
                s.samp_a   = $urandom_range(0, 1) ? '1 : '0;
                s.samp_b   = $urandom_range(0, 1) ? '1 : '0;
                s.samp_ref = $urandom_range(0, 1) ? '1 : '0;
            end
            FLAV_HIGH: begin
                s.samp_a   = SAMPLE_BITS'(4095 - $urandom_range(0, 200));
                s.samp_b   = SAMPLE_BITS'(4095 - $urandom_range(0, 200));
                s.samp_ref = SAMPLE_BITS'(4095 - $urandom_range(0, 200));
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_scan make_scan(int a, int b, int r);
        return '{SAMPLE_BITS'(a), SAMPLE_BITS'(b), SAMPLE_BITS'(r)};
    endfunction

    // monitor: handshakes, prediction and result checks
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && i_in_valid && !o_in_stall;
        cfg_fire <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            avg_count_q      = AVG_COUNT_RESET;
            ref_mv_q         = REF_MV_RESET;
            scan_phase       = '0;
            chan_sum[CH_A]   = '0;
            chan_sum[CH_B]   = '0;
            chan_sum[CH_REF] = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                apply_reg_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                fold_scan('{i_sample_a, i_sample_b, i_sample_ref});
                scans_sent++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    $error("result beat with no reading pending: %0d %0d %0d %0d",
                           o_volt_a, o_volt_b, o_supply_mv, o_ref_zero);
                    mismatches++;
                end else begin
                    t_reading want;
                    want = expected_readings.pop_front();
                    check_field("volt_a", want.volt_a, o_volt_a);
                    check_field("volt_b", want.volt_b, o_volt_b);
                    check_field("supply_mv", want.supply_mv, o_supply_mv);
                    check_field("ref_zero", OUT_W'(want.ref_zero), OUT_W'(o_ref_zero));
                    readings_checked++;
                    if (want.ref_zero)
                        zero_ref_seen++;
                    else if (want.volt_a == OUT_SAT || want.volt_b == OUT_SAT ||
                             want.supply_mv == OUT_SAT)
                        clipped_seen++;
                end
            end
        end
    end

    // scan driver: hold the beat until accepted, then advance or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (in_fire || !i_in_valid) begin
            if (in_gap != 0) begin
                i_in_valid <= 1'b0;
                in_gap     <= in_gap - 1;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                in_gap     <= $urandom_range(0, 12);
            end else if (scan_queue.size() != 0) begin
                pending_scan = scan_queue.pop_front();
                i_sample_a   <= pending_scan.samp_a;
                i_sample_b   <= pending_scan.samp_b;
                i_sample_ref <= pending_scan.samp_ref;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result backpressure in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n || !idling) begin
            i_out_stall <= 1'b0;
            out_gap     <= 0;
        end else if (out_gap != 0) begin
            i_out_stall <= 1'b1;
            out_gap     <= out_gap - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            out_gap     <= $urandom_range(0, 12);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for the sender to drain and every reading to arrive, then let the block settle
    task automatic settle();
        do begin
            @(negedge i_clk);
            #1;
        end while (scan_queue.size() != 0 || i_in_valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int          random_sent;
        int          pick;
        int          count;
        int          win;
        bit          big_done;
        logic [7:0]  avg_val;
        logic [11:0] mv_val;
        t_flavor     flav;

        random_sent = 0;
        big_done    = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one full window of ten scans, closed by an eleventh
        repeat (11) scan_queue.push_back(random_scan(FLAV_ANY));
        random_sent += 11;
        settle();

        // clipping, zero reference, exact full-scale ratios
        write_reg(CFG_AVG_COUNT, CFG_DATA_W'(1));
        write_reg(CFG_REF_MV, CFG_DATA_W'(4095));
        scan_queue.push_back(make_scan(4095, 4095, 1));
        scan_queue.push_back(make_scan(0, 0, 0));
        scan_queue.push_back(make_scan(4095, 0, 4095));
        scan_queue.push_back(make_scan(4095, 4095, 4095));
        scan_queue.push_back(make_scan(0, 0, 0));
        scan_queue.push_back(make_scan(1, 2, 3));
        scan_queue.push_back(make_scan(0, 4095, 4095));
        scan_queue.push_back(make_scan(0, 0, 0));
        settle();

        // zero reference voltage gives zero readings
        write_reg(CFG_REF_MV, CFG_DATA_W'(0));
        scan_queue.push_back(make_scan(4095, 4095, 4095));
        scan_queue.push_back(make_scan(0, 0, 0));
        settle();

        // window of zero acts as one; upper data bits are dropped
        write_reg(CFG_REF_MV, CFG_DATA_W'(1));
        write_reg(CFG_AVG_COUNT, CFG_DATA_W'(12'hF00));
        scan_queue.push_back(make_scan(1, 2, 2));
        scan_queue.push_back(make_scan(0, 0, 0));
        settle();

        // shrink the window mid-block: next scan closes it at once
        write_reg(CFG_AVG_COUNT, CFG_DATA_W'(5));
        write_reg(CFG_REF_MV, CFG_DATA_W'(2500));
        repeat (3) scan_queue.push_back(make_scan(1000, 2000, 1500));
        settle();
        write_reg(CFG_AVG_COUNT, CFG_DATA_W'(12'h102));
        write_reg(CFG_SPARE_LO, CFG_DATA_W'(12'hFFF));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'(12'h0A5));
        scan_queue.push_back(make_scan(4095, 4095, 4095));
        settle();

        while (random_sent < SCAN_TARGET) begin
            pick = $urandom_range(0, 19);
            if (!big_done && random_sent > 250) begin
                avg_val  = 8'd255;
                big_done = 1'b1;
            end else if (pick == 0) begin
                avg_val = 8'd0;
            end else if (pick < 14) begin
                avg_val = 8'($urandom_range(1, 4));
            end else begin
                avg_val = 8'($urandom_range(5, 20));
            end
            pick = $urandom_range(0, 9);
            mv_val = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : (pick == 2) ? 12'd1 :
                     12'($urandom_range(2, 4094));
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_AVG_COUNT, {4'($urandom), avg_val});
                write_reg(CFG_REF_MV, mv_val);
            end else begin
                write_reg(CFG_REF_MV, mv_val);
                write_reg(CFG_AVG_COUNT, {4'($urandom), avg_val});
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          CFG_DATA_W'($urandom));
            settings_visited++;

            // quiet handshakes over the tail of the run
            idling = ($urandom_range(0, 3) != 0) && (random_sent < SCAN_TARGET - 60);
            win    = (avg_val == 8'd0) ? 1 : int'(avg_val);
            count  = (avg_val == 8'd255) ? 256 + $urandom_range(0, 2) :
                     $urandom_range(1, 4 * (win + 1) + 2);
            repeat (count) begin
                pick = $urandom_range(0, 9);
                if (avg_val == 8'd255)
                    flav = (pick < 7) ? FLAV_HIGH : FLAV_ANY;
                else
                    flav = (pick < 6) ? FLAV_ANY : (pick < 8) ? FLAV_LOW_REF :
                           (pick < 9) ? FLAV_RAILS : FLAV_HIGH;
                scan_queue.push_back(random_scan(flav));
            end
            random_sent += count;
            settle();
        end

        $display("Sent %0d scans over %0d random settings plus corner cases, windows 0 to 255",
                 scans_sent, settings_visited);
        $display("Checked %0d readings: %0d with zero reference, %0d clipped",
                 readings_checked, zero_ref_seen, clipped_seen);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
